[hdl/smcp_pkg.sv]
// Shared types and constants for the serial motion command parser.
// Holds command/status structs, result kind codes and character codes.
// No dependencies.
`default_nettype none

package smcp_pkg;

	localparam int CMD_LEN = 15;
	localparam int POS_W   = 4;

	localparam logic [POS_W-1:0] POS_LSIGN  = 4'd0;
	localparam logic [POS_W-1:0] POS_LSPD_LO = 4'd1;
	localparam logic [POS_W-1:0] POS_LSPD_HI = 4'd4;
	localparam logic [POS_W-1:0] POS_RSIGN  = 4'd5;
	localparam logic [POS_W-1:0] POS_RSPD_LO = 4'd6;
	localparam logic [POS_W-1:0] POS_RSPD_HI = 4'd9;
	localparam logic [POS_W-1:0] POS_STEP_LO = 4'd10;
	localparam logic [POS_W-1:0] POS_LAST   = 4'd14;

	localparam int SPD_W   = 15;
	localparam int TGT_W   = 18;
	localparam int SMAG_W  = 14;
	localparam int CNT_W   = 17;
	localparam int DATA_W  = 72;
	localparam int KIND_W  = 3;

	localparam logic [KIND_W-1:0] KIND_DISARM   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_RESET    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_MOVE     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_INVALID  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_OVERFLOW = 3'd4;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic             wr_en;
		logic             start;
		logic             rd_en;
		logic [POS_W-1:0] rd_pos;
		logic             load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic term_hit;
		logic ovf_hit;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

[hdl/serial_motion_command_parser.sv]
// Top level of the serial motion command parser: joins smcp_ctrl and smcp_dp; uses smcp_pkg.
// Sequence: after a terminating byte the 15 stored bytes are read one per cycle (ST_READ)
// and pass the read register (ST_DRAIN), then the result is loaded (ST_FINISH); an overflow
// byte goes straight to ST_FINISH. Throughput: one byte per cycle between commands; the input
// stalls from a terminating or overflow byte until its result is loaded (waits on m_tready).
// Reset clears the fill count, controller state and output valid; store contents stay undefined.
`default_nettype none

module serial_motion_command_parser #(
	parameter int BUFFER_DEPTH = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [71:0] m_tdata,   // [14:0] left_speed, [29:15] right_speed,
	                               // [47:30] left_target, [65:48] right_target,
	                               // [71:66] zero
	output logic [2:0]  m_tuser    // [2:0] cmd_kind
);

	smcp_pkg::ctl_cmd_t cmd;
	smcp_pkg::dp_stat_t stat;

	smcp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	smcp_dp #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_byte  (s_tdata),
		.cmd      (cmd),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!m_tvalid || m_tready))
		else $error("result loaded over a pending request");

	a_term_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !s_tready)
		else $error("input taken while a command is parsed");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !cmd.wr_en)
		else $error("store written during read-out");

	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != smcp_pkg::KIND_MOVE)) |-> (m_tdata == '0))
		else $error("nonzero payload on a non-move result");

endmodule

`default_nettype wire

[hdl/smcp_ctrl.sv]
// Controller state machine for the serial motion command parser.
// Sequences byte intake, line read-out and result loading; uses smcp_pkg.
`default_nettype none

module smcp_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  smcp_pkg::dp_stat_t   stat,
	output smcp_pkg::ctl_cmd_t   cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t                     state_q;
	logic [smcp_pkg::POS_W-1:0] pos_q;

	always_comb begin
		s_tready     = (state_q == ST_IDLE);
		cmd.wr_en    = s_tvalid && (state_q == ST_IDLE);
		cmd.start    = cmd.wr_en && stat.term_hit;
		cmd.rd_en    = (state_q == ST_READ);
		cmd.rd_pos   = pos_q;
		cmd.load_out = (state_q == ST_FINISH) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					pos_q <= '0;
					if (cmd.wr_en && stat.term_hit) begin
						state_q <= ST_READ;
					end else if (cmd.wr_en && stat.ovf_hit) begin
						state_q <= ST_FINISH;
					end
				end
				ST_READ: begin
					if (pos_q == smcp_pkg::POS_LAST) begin
						state_q <= ST_DRAIN;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/smcp_dp.sv]
// Datapath for the serial motion command parser: line store, fill count,
// digit accumulators and the output register. Uses smcp_pkg.
`default_nettype none

module smcp_dp #(
	parameter int BUFFER_DEPTH = 64
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire  [7:0]                       rx_byte,
	input  smcp_pkg::ctl_cmd_t               cmd,
	output smcp_pkg::dp_stat_t               stat,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [smcp_pkg::DATA_W-1:0]      m_tdata,
	output logic [smcp_pkg::KIND_W-1:0]      m_tuser
);

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int POS_W = smcp_pkg::POS_W;
	localparam int SMAG_W = smcp_pkg::SMAG_W;
	localparam int CNT_W = smcp_pkg::CNT_W;
	localparam int SPD_W = smcp_pkg::SPD_W;
	localparam int TGT_W = smcp_pkg::TGT_W;

	logic [7:0]        line_store [BUFFER_DEPTH];
	logic [AW-1:0]     fill_q;
	logic              prev_hash_q;
	logic [AW:0]       len_q;
	logic              pend_ovf_q;

	logic [7:0]        rd_data_s1;
	logic              vld_s1;
	logic [POS_W-1:0]  pos_s1;

	logic              ended_q;
	logic [7:0]        b0_q;
	logic [7:0]        b5_q;
	logic              lrun_q, rrun_q, srun_q;
	logic [SMAG_W-1:0] lmag_q, rmag_q;
	logic [CNT_W-1:0]  steps_q;

	logic              m_tvalid_q;
	logic [smcp_pkg::DATA_W-1:0] m_tdata_q;
	logic [smcp_pkg::KIND_W-1:0] m_tuser_q;

	logic [7:0]        eff;
	logic              is_dig;
	logic [3:0]        dig;
	logic              in_lspd, in_rspd, in_step;

	logic [smcp_pkg::KIND_W-1:0] res_kind;
	logic              sign_ok;
	logic              lneg, rneg;
	logic signed [SPD_W-1:0] ls, rs;
	logic signed [TGT_W-1:0] lt, rt;

	assign stat.term_hit = (fill_q != '0) && prev_hash_q;
	assign stat.ovf_hit  = (fill_q == AW'(BUFFER_DEPTH - 1)) && !stat.term_hit;
	assign stat.out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			line_store[fill_q] <= rx_byte;
		end
		rd_data_s1 <= line_store[{{(AW-POS_W){1'b0}}, cmd.rd_pos}];
		pos_s1     <= cmd.rd_pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			prev_hash_q <= 1'b0;
			vld_s1      <= 1'b0;
			pend_ovf_q  <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd_en;
			if (cmd.wr_en) begin
				prev_hash_q <= (rx_byte == smcp_pkg::CH_HASH);
				if (stat.term_hit || stat.ovf_hit) begin
					fill_q <= '0;
				end else begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.start) begin
				pend_ovf_q <= 1'b0;
			end else if (cmd.wr_en && stat.ovf_hit) begin
				pend_ovf_q <= 1'b1;
			end
		end
	end

	always_comb begin
		eff = rd_data_s1;
		if (ended_q || ({{(AW+1-POS_W){1'b0}}, pos_s1} >= len_q)) begin
			eff = 8'h00;
		end
		is_dig  = (eff >= smcp_pkg::CH_ZERO) && (eff <= smcp_pkg::CH_NINE);
		dig     = eff[3:0];
		in_lspd = (pos_s1 >= smcp_pkg::POS_LSPD_LO) && (pos_s1 <= smcp_pkg::POS_LSPD_HI);
		in_rspd = (pos_s1 >= smcp_pkg::POS_RSPD_LO) && (pos_s1 <= smcp_pkg::POS_RSPD_HI);
		in_step = (pos_s1 >= smcp_pkg::POS_STEP_LO);
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			len_q   <= {1'b0, fill_q} + 1'b1;
			ended_q <= 1'b0;
			lrun_q  <= 1'b1;
			rrun_q  <= 1'b1;
			srun_q  <= 1'b1;
			lmag_q  <= '0;
			rmag_q  <= '0;
			steps_q <= '0;
			b0_q    <= 8'h00;
			b5_q    <= 8'h00;
		end else if (vld_s1) begin
			if (eff == 8'h00) begin
				ended_q <= 1'b1;
			end
			if (pos_s1 == smcp_pkg::POS_LSIGN) begin
				b0_q <= eff;
			end
			if (pos_s1 == smcp_pkg::POS_RSIGN) begin
				b5_q <= eff;
			end
			if (in_lspd) begin
				if (lrun_q && is_dig) begin
					lmag_q <= (lmag_q << 3) + (lmag_q << 1) + SMAG_W'(dig);
				end else begin
					lrun_q <= 1'b0;
				end
			end
			if (in_rspd) begin
				if (rrun_q && is_dig) begin
					rmag_q <= (rmag_q << 3) + (rmag_q << 1) + SMAG_W'(dig);
				end else begin
					rrun_q <= 1'b0;
				end
			end
			if (in_step) begin
				if (srun_q && is_dig) begin
					steps_q <= (steps_q << 3) + (steps_q << 1) + CNT_W'(dig);
				end else begin
					srun_q <= 1'b0;
				end
			end
		end
	end

	always_comb begin
		sign_ok = ((b0_q == smcp_pkg::CH_PLUS) || (b0_q == smcp_pkg::CH_MINUS))
			&& ((b5_q == smcp_pkg::CH_PLUS) || (b5_q == smcp_pkg::CH_MINUS));
		if (pend_ovf_q) begin
			res_kind = smcp_pkg::KIND_OVERFLOW;
		end else if (b0_q == smcp_pkg::CH_D) begin
			res_kind = smcp_pkg::KIND_DISARM;
		end else if (b0_q == smcp_pkg::CH_R) begin
			res_kind = smcp_pkg::KIND_RESET;
		end else if (!sign_ok) begin
			res_kind = smcp_pkg::KIND_INVALID;
		end else begin
			res_kind = smcp_pkg::KIND_MOVE;
		end
		lneg = (b0_q == smcp_pkg::CH_MINUS) && (lmag_q != '0);
		rneg = (b5_q == smcp_pkg::CH_PLUS) && (rmag_q != '0);
		ls = lneg ? -$signed({1'b0, lmag_q}) : $signed({1'b0, lmag_q});
		rs = rneg ? -$signed({1'b0, rmag_q}) : $signed({1'b0, rmag_q});
		lt = lneg ? -$signed({1'b0, steps_q}) : $signed({1'b0, steps_q});
		rt = rneg ? -$signed({1'b0, steps_q}) : $signed({1'b0, steps_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_tuser_q <= res_kind;
			if (res_kind == smcp_pkg::KIND_MOVE) begin
				m_tdata_q <= {6'b0, rt, lt, rs, ls};
			end else begin
				m_tdata_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

[verif/testbench.sv]
// Testbench for serial_motion_command_parser: a table of directed command lines, then
// random command traffic with stalls on both stream sides, checked by a line decoder.
// Depends on hdl/smcp_pkg.sv and hdl/serial_motion_command_parser.sv.
`timescale 1ns / 100ps

module testbench;

	localparam int DEPTH = 64;
	localparam int RANDOM_BYTES = 1300;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [7:0] ZERO_MARK = 8'h7E;
	localparam logic [7:0] FILLER = 8'h78;

	typedef struct packed {
		logic [smcp_pkg::KIND_W-1:0] kind;
		logic [smcp_pkg::SPD_W-1:0]  left_speed;
		logic [smcp_pkg::SPD_W-1:0]  right_speed;
		logic [smcp_pkg::TGT_W-1:0]  left_target;
		logic [smcp_pkg::TGT_W-1:0]  right_target;
	} cmd_result_t;

	typedef struct {
		string       head;
		int          fill_n;
		string       tail;
		bit          typed;
		cmd_result_t res;
	} line_row_t;

	localparam cmd_result_t NO_RESULT = '0;

	logic                        clk;
	logic                        arst_n;
	logic                        s_tvalid;
	logic                        s_tready;
	logic [7:0]                  s_tdata;
	logic                        m_tvalid;
	logic                        m_tready;
	logic [smcp_pkg::DATA_W-1:0] m_tdata;
	logic [smcp_pkg::KIND_W-1:0] m_tuser;

	logic [7:0]  line_buf [DEPTH];
	int          line_fill;
	logic [7:0]  line_bytes [$];
	cmd_result_t pending_cmds [$];
	line_row_t   directed_rows [$];

	int bytes_sent;
	int results_seen;
	int mismatches;
	int kind_seen [5];
	int out_wait;
	int cycle_cnt;
	bit hold_out;
	bit no_idle;

	serial_motion_command_parser #(.BUFFER_DEPTH(DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic cmd_result_t mk_result(input logic [smcp_pkg::KIND_W-1:0] kind,
		input int ls, input int rs, input int lt, input int rt);
		cmd_result_t r;
		r.kind = kind;
		r.left_speed = smcp_pkg::SPD_W'(ls);
		r.right_speed = smcp_pkg::SPD_W'(rs);
		r.left_target = smcp_pkg::TGT_W'(lt);
		r.right_target = smcp_pkg::TGT_W'(rt);
		return r;
	endfunction

	function automatic int field_value(input logic [smcp_pkg::CMD_LEN-1:0][7:0] cmd,
		input int first, input int n);
		int v;
		v = 0;
		for (int i = 0; i < n; i++) begin
			if (cmd[first + i] < smcp_pkg::CH_ZERO || cmd[first + i] > smcp_pkg::CH_NINE)
				break;
			v = v * 10 + int'(cmd[first + i] - smcp_pkg::CH_ZERO);
		end
		return v;
	endfunction

	task automatic decode_rx_byte(input logic [7:0] b, output bit got, output cmd_result_t res);
		logic [smcp_pkg::CMD_LEN-1:0][7:0] cmd;
		logic [7:0] c;
		int len, lmag, rmag, steps, ls, rs;
		bit ended;
		got = 1'b0;
		res = NO_RESULT;
		if (line_fill >= DEPTH)
			line_fill = 0;
		line_buf[line_fill] = b;
		line_fill++;
		if (!(line_fill > 1 && line_buf[line_fill - 2] == smcp_pkg::CH_HASH)) begin
			if (line_fill >= DEPTH) begin
				line_fill = 0;
				got = 1'b1;
				res.kind = smcp_pkg::KIND_OVERFLOW;
			end
		end else begin
			len = line_fill;
			line_fill = 0;
			ended = 1'b0;
			for (int i = 0; i < smcp_pkg::CMD_LEN; i++) begin
				c = 8'h00;
				if (!ended && i < len) begin
					c = line_buf[i];
					if (c == 8'h00)
						ended = 1'b1;
				end
				cmd[i] = c;
			end
			got = 1'b1;
			if (cmd[smcp_pkg::POS_LSIGN] == smcp_pkg::CH_D) begin
				res.kind = smcp_pkg::KIND_DISARM;
			end else if (cmd[smcp_pkg::POS_LSIGN] == smcp_pkg::CH_R) begin
				res.kind = smcp_pkg::KIND_RESET;
			end else if (!(cmd[smcp_pkg::POS_LSIGN] inside
					{smcp_pkg::CH_PLUS, smcp_pkg::CH_MINUS}) ||
				!(cmd[smcp_pkg::POS_RSIGN] inside
					{smcp_pkg::CH_PLUS, smcp_pkg::CH_MINUS})) begin
				res.kind = smcp_pkg::KIND_INVALID;
			end else begin
				lmag = field_value(cmd, smcp_pkg::POS_LSPD_LO, 4);
				rmag = field_value(cmd, smcp_pkg::POS_RSPD_LO, 4);
				steps = field_value(cmd, smcp_pkg::POS_STEP_LO, 5);
				ls = (cmd[smcp_pkg::POS_LSIGN] == smcp_pkg::CH_PLUS) ? lmag : -lmag;
				rs = (cmd[smcp_pkg::POS_RSIGN] == smcp_pkg::CH_PLUS) ? -rmag : rmag;
				res = mk_result(smcp_pkg::KIND_MOVE, ls, rs, (ls < 0) ? -steps : steps,
					(rs < 0) ? -steps : steps);
			end
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("ERROR at %0t, result %0d: %s is %0h, expected %0h",
			$time, results_seen, what, got, want);
	endtask

	task automatic check_result(input logic [smcp_pkg::KIND_W-1:0] kind,
		input logic [smcp_pkg::DATA_W-1:0] data);
		cmd_result_t want;
		results_seen++;
		if (kind <= smcp_pkg::KIND_OVERFLOW)
			kind_seen[kind]++;
		if (pending_cmds.size() == 0) begin
			report_mismatch("unexpected result, cmd_kind", kind, 0);
		end else begin
			want = pending_cmds.pop_front();
			if (kind !== want.kind)
				report_mismatch("cmd_kind", kind, want.kind);
			if (data[14:0] !== want.left_speed)
				report_mismatch("left_speed", data[14:0], want.left_speed);
			if (data[29:15] !== want.right_speed)
				report_mismatch("right_speed", data[29:15], want.right_speed);
			if (data[47:30] !== want.left_target)
				report_mismatch("left_target", data[47:30], want.left_target);
			if (data[65:48] !== want.right_target)
				report_mismatch("right_target", data[65:48], want.right_target);
			if (data[smcp_pkg::DATA_W-1:66] !== '0)
				report_mismatch("tdata padding", data[smcp_pkg::DATA_W-1:66], 0);
		end
	endtask

	task automatic offer_byte(input logic [7:0] b, output bit got, output cmd_result_t res);
		int gap;
		gap = no_idle ? 0 : $urandom_range(3);
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		decode_rx_byte(b, got, res);
	endtask

	task automatic send_line(input bit typed, input cmd_result_t typed_res);
		bit got;
		cmd_result_t res;
		for (int i = 0; i < line_bytes.size(); i++) begin
			offer_byte(line_bytes[i], got, res);
			if (typed && i == line_bytes.size() - 1)
				pending_cmds.push_back(typed_res);
			else if (got)
				pending_cmds.push_back(res);
		end
		line_bytes.delete();
	endtask

	task automatic add_row(input string head, input int fill_n, input string tail,
		input bit typed, input cmd_result_t res);
		line_row_t row;
		row.head = head;
		row.fill_n = fill_n;
		row.tail = tail;
		row.typed = typed;
		row.res = res;
		directed_rows.push_back(row);
	endtask

	// '~' in the table stands for a zero byte
	task automatic append_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_bytes.push_back((s[i] == ZERO_MARK) ? 8'h00 : s[i]);
	endtask

	function automatic logic [7:0] rand_plain();
		logic [7:0] v;
		v = 8'($urandom_range(255));
		return (v == smcp_pkg::CH_HASH) ? FILLER : v;
	endfunction

	function automatic logic [7:0] rand_digit();
		if ($urandom_range(99) < 8)
			return 8'($urandom_range(255));
		return smcp_pkg::CH_ZERO + 8'($urandom_range(9));
	endfunction

	function automatic logic [7:0] sign_byte(input int bad_pct);
		if ($urandom_range(99) < bad_pct)
			return 8'($urandom_range(255));
		return $urandom_range(1) ? smcp_pkg::CH_PLUS : smcp_pkg::CH_MINUS;
	endfunction

	task automatic close_line();
		line_bytes.push_back(smcp_pkg::CH_HASH);
		line_bytes.push_back(8'($urandom_range(255)));
	endtask

	task automatic compose_move(input int bad_pct, input int zero_at, input int cut_at);
		for (int i = 0; i < smcp_pkg::CMD_LEN; i++) begin
			if (i == smcp_pkg::POS_LSIGN || i == smcp_pkg::POS_RSIGN)
				line_bytes.push_back(sign_byte(bad_pct));
			else
				line_bytes.push_back(rand_digit());
		end
		if (zero_at >= 0)
			line_bytes[zero_at] = 8'h00;
		while (cut_at >= 0 && line_bytes.size() > cut_at)
			void'(line_bytes.pop_back());
		close_line();
	endtask

	initial begin : receiver
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_out) begin
				m_tready <= 1'b0;
			end else if (out_wait != 0) begin
				m_tready <= 1'b0;
				out_wait--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : monitor
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				check_result(m_tuser, m_tdata);
				out_wait = no_idle ? 0 : $urandom_range(3);
			end
		end
	end

	initial begin : backpressure
		hold_out = 1'b0;
		wait (bytes_sent >= 700);
		@(posedge clk);
		hold_out = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_out = 1'b0;
	end

	initial begin : watchdog
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		int random_start;
		int pick;
		int cut_at;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		no_idle = 1'b0;
		out_wait = 0;
		line_fill = 0;
		bytes_sent = 0;
		results_seen = 0;
		mismatches = 0;
		foreach (kind_seen[k])
			kind_seen[k] = 0;

		add_row("D#\n", 0, "", 1, mk_result(smcp_pkg::KIND_DISARM, 0, 0, 0, 0));
		add_row("R#\n", 0, "", 1, mk_result(smcp_pkg::KIND_RESET, 0, 0, 0, 0));
		add_row("#x", 0, "", 1, mk_result(smcp_pkg::KIND_INVALID, 0, 0, 0, 0));
		add_row("+9999-999999999#\n", 0, "", 1,
			mk_result(smcp_pkg::KIND_MOVE, 9999, 9999, 99999, 99999));
		add_row("-9999+999999999#\n", 0, "", 1,
			mk_result(smcp_pkg::KIND_MOVE, -9999, -9999, -99999, -99999));
		add_row("+0000-000000000#\n", 0, "", 1,
			mk_result(smcp_pkg::KIND_MOVE, 0, 0, 0, 0));
		add_row("+1234-56#\n", 0, "", 0, NO_RESULT);
		add_row("+5#\n", 0, "", 0, NO_RESULT);
		add_row("+1234-5678012~4#\n", 0, "", 0, NO_RESULT);
		add_row("-1a34+12b4123c5#\n", 0, "", 0, NO_RESULT);
		add_row("-0005+000300077#\n", 0, "", 0, NO_RESULT);
		add_row("A1234-567812345#\n", 0, "", 1,
			mk_result(smcp_pkg::KIND_INVALID, 0, 0, 0, 0));
		add_row("+1234*567812345#\n", 0, "", 1,
			mk_result(smcp_pkg::KIND_INVALID, 0, 0, 0, 0));
		add_row("~#\n", 0, "", 1, mk_result(smcp_pkg::KIND_INVALID, 0, 0, 0, 0));
		add_row("D", DEPTH - 3, "#y", 1, mk_result(smcp_pkg::KIND_DISARM, 0, 0, 0, 0));
		add_row("a", DEPTH - 1, "", 1, mk_result(smcp_pkg::KIND_OVERFLOW, 0, 0, 0, 0));
		add_row("R#\n", 0, "", 1, mk_result(smcp_pkg::KIND_RESET, 0, 0, 0, 0));

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[r]) begin
			append_text(directed_rows[r].head);
			repeat (directed_rows[r].fill_n)
				line_bytes.push_back(FILLER);
			append_text(directed_rows[r].tail);
			send_line(directed_rows[r].typed, directed_rows[r].res);
		end

		random_start = bytes_sent;
		while (bytes_sent - random_start < RANDOM_BYTES) begin
			no_idle = ((bytes_sent / 160) % 4) == 2;
			pick = $urandom_range(99);
			cut_at = ($urandom_range(9) == 0) ? $urandom_range(smcp_pkg::CMD_LEN - 1) : -1;
			if (pick < 48) begin
				compose_move(0, -1, cut_at);
			end else if (pick < 56) begin
				compose_move(40, -1, -1);
			end else if (pick < 64) begin
				compose_move(0, $urandom_range(1, smcp_pkg::CMD_LEN - 1), -1);
			end else if (pick < 72) begin
				line_bytes.push_back($urandom_range(1) ? smcp_pkg::CH_D : smcp_pkg::CH_R);
				repeat ($urandom_range(14))
					line_bytes.push_back(rand_plain());
				close_line();
			end else if (pick < 86) begin
				repeat ($urandom_range(1, 20))
					line_bytes.push_back(8'($urandom_range(255)));
				close_line();
			end else if (pick < 93) begin
				repeat (DEPTH + $urandom_range(8))
					line_bytes.push_back(rand_plain());
			end else begin
				// finish the command on the last free store entry
				line_bytes.push_back(sign_byte(0));
				repeat (DEPTH - 3)
					line_bytes.push_back(rand_plain());
				close_line();
			end
			send_line(1'b0, NO_RESULT);
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d bytes (%0d random) and %0d results, %0d mismatches.",
			bytes_sent, bytes_sent - random_start, results_seen, mismatches);
		$display("Kinds seen: %0d disarm, %0d scanner reset, %0d move, %0d invalid, %0d overflow.",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
